// ----- rtl/aes_pkg.sv -----
// AES-128 package: types, S-box, round constants and round functions.
`timescale 1ns / 1ps
package aes_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned HALF_W   = 64;
    localparam int unsigned BLOCK_W  = 128;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NUM_ROUNDS = 10;

    localparam logic [KEY_W-1:0] KEY_RESET_0 = 32'h2B7E1516;
    localparam logic [KEY_W-1:0] KEY_RESET_1 = 32'h28AED2A6;
    localparam logic [KEY_W-1:0] KEY_RESET_2 = 32'hABF71588;
    localparam logic [KEY_W-1:0] KEY_RESET_3 = 32'h09CF4F3C;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 2'd3;

    typedef logic [BLOCK_W-1:0] t_block;

    // round key and block travel together down the pipe
    typedef struct packed {
        t_block state;
        t_block rkey;
    } t_stage;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    // round constant for round r (1..10)
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block (FIPS order, byte 0 in the top bits)
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    // next round key from the previous one
    function automatic t_block next_key(input t_block k, input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows, optional MixColumns
    function automatic t_block round_fn(input t_block s, input logic do_mix);
        t_block t, o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(c*4+r) -: 8] = sbox(get_byte(s, ((c + r) % 4) * 4 + r));
            end
        end
        o = t;
        if (do_mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(t, c*4);
                a1 = get_byte(t, c*4+1);
                a2 = get_byte(t, c*4+2);
                a3 = get_byte(t, c*4+3);
                al = a0 ^ a1 ^ a2 ^ a3;
                o[BLOCK_W-1-8*(c*4)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                o[BLOCK_W-1-8*(c*4+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                o[BLOCK_W-1-8*(c*4+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                o[BLOCK_W-1-8*(c*4+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        return o;
    endfunction

endpackage

// ----- rtl/aes_round.sv -----
// One AES round stage: round function, key expansion step and stage register.
`timescale 1ns / 1ps
module aes_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_round,
    input  logic              i_en,
    input  logic              i_valid,
    input  aes_pkg::t_stage   i_data,
    output logic              o_valid,
    output aes_pkg::t_stage   o_data
);
    import aes_pkg::*;

    logic    r_valid;
    t_stage  r_data;
    t_stage  n_data;
    t_block  w_key;

    always_comb begin
        w_key        = next_key(i_data.rkey, i_round);
        n_data.rkey  = w_key;
        n_data.state = round_fn(i_data.state, i_round != 4'(NUM_ROUNDS)) ^ w_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- rtl/aes128_block_encrypt.sv -----
// Top level: AES-128 encryption pipeline with key registers and stream ports.
`timescale 1ns / 1ps
// AES-128 block encryptor, one 128-bit block per beat.
// Slave channel s_axis_*: tdata = {plain_lower, plain_upper} (plain_upper in
// bits 63:0). Master channel m_axis_*: tdata = {cipher_lower, cipher_upper}.
// Byte 0 of each half is in that half's top bits (FIPS order).
// Config: i_cfg_we / i_cfg_idx / i_cfg_data write key words 0..3; write only
// while the pipe is empty. Each beat captures the key at entry.
// Pipeline: an input register with the initial AddRoundKey, then ten round
// stages each holding one round plus one key expansion step, eleven register
// stages counting the input register. The pipe takes one block per cycle
// whenever the receiver does not stall the output.
// The pipe advances as a whole: when the receiver stalls with a valid result
// at the output, every stage holds and s_axis_tready drops; bubbles are not
// squeezed out. Reset clears all valid bits and loads the default key.
module aes128_block_encrypt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aes_pkg::KEY_W-1:0]   i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [127:0]                s_axis_tdata,  // plain_lower, plain_upper
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [127:0]                m_axis_tdata   // cipher_lower, cipher_upper
);
    import aes_pkg::*;

    logic [KEY_W-1:0] r_key [4];
    logic             w_en;
    logic             w_valid [NUM_ROUNDS+1];
    t_stage           w_data  [NUM_ROUNDS+1];
    logic             r_v0;
    t_stage           r_d0;
    t_block           w_key;
    t_block           w_plain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY_RESET_0;
            r_key[1] <= KEY_RESET_1;
            r_key[2] <= KEY_RESET_2;
            r_key[3] <= KEY_RESET_3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_0: r_key[0] <= i_cfg_data;
                REG_KEY_1: r_key[1] <= i_cfg_data;
                REG_KEY_2: r_key[2] <= i_cfg_data;
                REG_KEY_3: r_key[3] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // global stall: hold every pipeline stage while the last stage waits
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_key   = {r_key[0], r_key[1], r_key[2], r_key[3]};
    assign w_plain = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    // stage 0: initial AddRoundKey
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0.state <= w_plain ^ w_key;
            r_d0.rkey  <= w_key;
        end
    end

    assign w_valid[0] = r_v0;
    assign w_data[0]  = r_d0;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (4'(g + 1)),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign m_axis_tvalid = w_valid[NUM_ROUNDS];
    assign m_axis_tdata  = {w_data[NUM_ROUNDS].state[HALF_W-1:0],
                            w_data[NUM_ROUNDS].state[BLOCK_W-1:HALF_W]};
endmodule
